[rtl/core/multi_input_debounce_scanner_unit_defines.svh]
// Assertion macros shared by the debounce scanner.
`ifndef MULTI_INPUT_DEBOUNCE_SCANNER_UNIT_DEFINES_SVH
`define MULTI_INPUT_DEBOUNCE_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MIDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MIDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/mids_pkg.sv]
`default_nettype none

package mids_pkg;

    localparam int CHANNELS = 6;
    localparam int PIN_BITS = 6;
    localparam int TICK_W   = 32;
    localparam int CHAN_W   = 3;

    localparam logic [TICK_W-1:0] HOLD_RESET = TICK_W'(20000);

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [TICK_W-1:0] t_tick;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_TIMING   = 2'd1,
        PH_ASSERTED = 2'd2
    } t_phase;

    typedef enum logic {
        MODE_SCAN  = 1'b0,
        MODE_CLEAR = 1'b1
    } t_mode;

    typedef struct packed {
        logic  go;
        logic  found;
        t_chan chan;
    } t_chain;

endpackage

`default_nettype wire

[rtl/core/mids_cell.sv]
`default_nettype none

module mids_cell
    import mids_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_step,
    input  wire logic   i_clear,
    input  wire t_chan  i_cell_index,
    input  wire t_tick  i_now_tick,
    input  wire t_tick  i_hold_ticks,
    input  wire logic   i_low,
    input  wire t_chain i_chain,
    output t_chain      o_chain
);

    t_phase r_phase;
    t_phase n_phase;
    t_tick  r_start_tick;
    t_tick  n_start_tick;
    t_tick  elapsed;
    logic   asserted_new;

    assign elapsed = i_now_tick - r_start_tick;

    always_comb begin
        n_phase      = r_phase;
        n_start_tick = r_start_tick;
        if (i_clear) begin
            n_phase = PH_IDLE;
        end else if (i_step && i_chain.go) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_low) begin
                        n_start_tick = i_now_tick;
                        n_phase      = PH_TIMING;
                    end
                end
                PH_TIMING: begin
                    if (!i_low) begin
                        n_phase = PH_IDLE;
                    end else if (elapsed > i_hold_ticks) begin
                        n_phase = PH_ASSERTED;
                    end
                end
                PH_ASSERTED: begin
                    if (!i_low) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        asserted_new  = i_chain.go && (n_phase == PH_ASSERTED);
        o_chain.go    = i_chain.go && !asserted_new;
        o_chain.found = i_chain.found || asserted_new;
        o_chain.chan  = asserted_new ? i_cell_index : i_chain.chan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start_tick <= n_start_tick;
    end

endmodule

`default_nettype wire

[rtl/core/multi_input_debounce_scanner_unit.sv]
// A result is offered in the cycle after its item is accepted. One item is
// taken per cycle while the output register is empty or being read; the
// channel cells update together in that cycle, with the priority stop
// rippling along the row of cells. Reset clears every channel to idle, sets
// hold_ticks to 20000 and empties the output register.
`default_nettype none

`include "multi_input_debounce_scanner_unit_defines.svh"

module multi_input_debounce_scanner_unit
    import mids_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_mode,
    input  wire logic [TICK_W-1:0]   i_now_tick,
    input  wire logic [PIN_BITS-1:0] i_pin_levels,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic                     o_found,
    output logic [CHAN_W-1:0]        o_channel,
    input  wire logic                i_hold_ticks_we,
    input  wire logic [TICK_W-1:0]   i_hold_ticks_wdata
);

    t_tick  r_hold_ticks;
    logic   r_out_valid;
    logic   r_found;
    t_chan  r_channel;
    logic   accept;
    logic   step;
    logic   clear;
    t_chain chain [CHANNELS+1];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign step       = accept && (i_mode == MODE_SCAN);
    assign clear      = accept && (i_mode == MODE_CLEAR);

    assign chain[0] = '{go: 1'b1, found: 1'b0, chan: '0};

    for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
        logic low;
        if (g < PIN_BITS) begin : g_pin
            assign low = !i_pin_levels[g];
        end else begin : g_nopin
            assign low = 1'b0;
        end
        mids_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_step       (step),
            .i_clear      (clear),
            .i_cell_index (CHAN_W'(g)),
            .i_now_tick   (i_now_tick),
            .i_hold_ticks (r_hold_ticks),
            .i_low        (low),
            .i_chain      (chain[g]),
            .o_chain      (chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= HOLD_RESET;
        end else if (i_hold_ticks_we) begin
            r_hold_ticks <= i_hold_ticks_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_found   <= step && chain[CHANNELS].found;
            r_channel <= step ? chain[CHANNELS].chan : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_channel   = r_channel;

    `MIDS_ASSERT_NEXT(a_clear_result, clear, o_out_valid && !o_found && o_channel == '0, "clear item did not give an empty result")
    `MIDS_ASSERT_NEXT(a_accept_gives_result, accept, o_out_valid, "accepted item gave no result")
    `MIDS_ASSERT_NOW(a_none_channel_zero, o_out_valid && !o_found, o_channel == '0, "channel not zero when nothing found")
    `MIDS_ASSERT_NOW(a_channel_range, o_out_valid && o_found, 32'(o_channel) < CHANNELS, "reported channel out of range")

endmodule

`default_nettype wire

[dv/multi_input_debounce_scanner_unit_test.sv]
`default_nettype none

module multi_input_debounce_scanner_unit_test;
    import mids_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 200;

    typedef struct {
        logic  found;
        t_chan chan;
    } scan_hit_t;

    class debounce_scoreboard;
        t_phase    phase_q[CHANNELS];
        t_tick     start_tick[CHANNELS];
        logic      asserted_q[CHANNELS];
        t_tick     hold;
        scan_hit_t expected_hits[$];
        int        fails;

        function new();
            for (int i = 0; i < CHANNELS; i++) begin
                phase_q[i]    = PH_IDLE;
                start_tick[i] = '0;
                asserted_q[i] = 1'b0;
            end
            hold  = HOLD_RESET;
            fails = 0;
        endfunction

        function void note_item(t_mode mode, t_tick now, logic [PIN_BITS-1:0] pins);
            scan_hit_t hit;
            logic      low;
            t_tick     elapsed;
            hit.found = 1'b0;
            hit.chan  = '0;
            if (mode == MODE_CLEAR) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    phase_q[i]    = PH_IDLE;
                    asserted_q[i] = 1'b0;
                end
            end else begin
                for (int i = 0; i < CHANNELS; i++) begin
                    low = (i < PIN_BITS) ? ~pins[i] : 1'b0;
                    case (phase_q[i])
                        PH_IDLE: begin
                            if (low) begin
                                start_tick[i] = now;
                                phase_q[i]    = PH_TIMING;
                            end
                        end
                        PH_TIMING: begin
                            elapsed = now - start_tick[i];
                            if (!low) begin
                                phase_q[i] = PH_IDLE;
                            end else if (elapsed > hold) begin
                                phase_q[i]    = PH_ASSERTED;
                                asserted_q[i] = 1'b1;
                            end
                        end
                        PH_ASSERTED: begin
                            if (!low) begin
                                phase_q[i]    = PH_IDLE;
                                asserted_q[i] = 1'b0;
                            end
                        end
                        default: begin
                            phase_q[i]    = PH_IDLE;
                            asserted_q[i] = 1'b0;
                        end
                    endcase
                    if (asserted_q[i]) begin
                        hit.found = 1'b1;
                        hit.chan  = t_chan'(i);
                        break;
                    end
                end
            end
            expected_hits.push_back(hit);
        endfunction

        task report_mismatch(input string what);
            $display("mismatch at %0t: %s", $realtime, what);
            fails++;
        endtask

        task check_result(input logic found, input t_chan chan);
            scan_hit_t hit;
            if (expected_hits.size() == 0) begin
                report_mismatch($sformatf("result found=%0d channel=%0d with no item waiting",
                                          found, chan));
            end else begin
                hit = expected_hits.pop_front();
                if (found !== hit.found) begin
                    report_mismatch($sformatf("found %0d, expected %0d", found, hit.found));
                end
                if (chan !== hit.chan) begin
                    report_mismatch($sformatf("channel %0d, expected %0d", chan, hit.chan));
                end
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_mode;
    logic [TICK_W-1:0]   i_now_tick;
    logic [PIN_BITS-1:0] i_pin_levels;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_found;
    logic [CHAN_W-1:0]   o_channel;
    logic                i_hold_ticks_we;
    logic [TICK_W-1:0]   i_hold_ticks_wdata;

    debounce_scoreboard sb;
    logic               quiet;
    int                 stall_left;
    int                 stall_roll;
    int                 cycle_count;

    multi_input_debounce_scanner_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (i_mode),
        .i_now_tick         (i_now_tick),
        .i_pin_levels       (i_pin_levels),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_found            (o_found),
        .o_channel          (o_channel),
        .i_hold_ticks_we    (i_hold_ticks_we),
        .i_hold_ticks_wdata (i_hold_ticks_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("multi_input_debounce_scanner_unit regression: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (quiet) begin
            i_out_ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 70) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                stall_left = (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_found, o_channel);
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 65) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Entered and left at a falling edge; valid stays high between back-to-back items.
    task automatic send_item(input t_mode mode, input t_tick tick,
                             input logic [PIN_BITS-1:0] pins);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_now_tick   <= tick;
        i_pin_levels <= pins;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(mode, tick, pins);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_hits.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_hold(input t_tick value);
        wait_drained();
        i_hold_ticks_we    <= 1'b1;
        i_hold_ticks_wdata <= value;
        @(negedge i_clk);
        i_hold_ticks_we <= 1'b0;
        sb.hold = value;
    endtask

    task automatic run_directed();
        send_item(MODE_SCAN, 32'd0, 6'b111111);
        send_item(MODE_SCAN, 32'd100, 6'b000000);
        send_item(MODE_SCAN, 32'd20100, 6'b000000);
        send_item(MODE_SCAN, 32'd20101, 6'b000000);
        send_item(MODE_SCAN, 32'd20102, 6'b000001);
        send_item(MODE_SCAN, 32'd20103, 6'b011111);
        send_item(MODE_CLEAR, 32'hFFFF_FFFF, 6'b000000);
        send_item(MODE_SCAN, 32'hFFFF_FF00, 6'b000000);
        send_item(MODE_SCAN, 32'd20000, 6'b000000);
        send_item(MODE_SCAN, 32'd20001, 6'b111111);
        send_item(MODE_CLEAR, 32'h5555_5555, 6'b101010);
        write_hold(32'd0);
        send_item(MODE_SCAN, 32'd7, 6'b101010);
        send_item(MODE_SCAN, 32'd7, 6'b101010);
        send_item(MODE_SCAN, 32'd8, 6'b101010);
        send_item(MODE_SCAN, 32'd9, 6'b101011);
        write_hold(32'hFFFF_FFFF);
        send_item(MODE_CLEAR, 32'd0, 6'b000000);
        send_item(MODE_SCAN, 32'd0, 6'b000000);
        send_item(MODE_SCAN, 32'hFFFF_FFFF, 6'b000000);
        send_item(MODE_SCAN, 32'd0, 6'b000000);
    endtask

    // Mostly coherent tick sequences with bouncing pins, plus clears and random noise.
    task automatic run_random_phase(input t_tick hold_value, input int count);
        t_tick               tick;
        t_tick               span;
        logic [PIN_BITS-1:0] pins;
        int                  roll;
        int                  ch;
        write_hold(hold_value);
        tick = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 50000)
                                           : t_tick'($urandom());
        pins = PIN_BITS'($urandom());
        span = (hold_value < 30000) ? hold_value / 2 + 3 : 15000;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                send_item(MODE_CLEAR, t_tick'($urandom()), PIN_BITS'($urandom()));
            end else if (roll < 6) begin
                send_item(MODE_SCAN, t_tick'($urandom()), PIN_BITS'($urandom()));
            end else begin
                roll = $urandom_range(0, 9);
                if (roll == 7) begin
                    ch   = $urandom_range(0, CHANNELS - 1);
                    tick = sb.start_tick[ch] + hold_value + t_tick'($urandom_range(0, 1));
                end else if (roll == 8) begin
                    tick = tick + t_tick'($urandom());
                end else if (roll == 9) begin
                    tick = tick + hold_value;
                end else if (roll != 0) begin
                    tick = tick + t_tick'($urandom_range(0, span));
                end
                if ($urandom_range(0, 19) == 0) begin
                    pins = PIN_BITS'($urandom());
                end else begin
                    for (int b = 0; b < PIN_BITS; b++) begin
                        if ($urandom_range(0, 7) == 0) begin
                            pins[b] = ~pins[b];
                        end
                    end
                end
                send_item(MODE_SCAN, tick, pins);
            end
        end
    endtask

    initial begin
        t_tick holds[8];
        sb                 = new();
        quiet              = 1'b0;
        stall_left         = 0;
        cycle_count        = 0;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_mode             = MODE_SCAN;
        i_now_tick         = '0;
        i_pin_levels       = '1;
        i_out_ready        = 1'b0;
        i_hold_ticks_we    = 1'b0;
        i_hold_ticks_wdata = '0;
        holds[0] = 32'd1000;
        holds[1] = 32'd0;
        holds[2] = 32'd1;
        holds[3] = t_tick'($urandom_range(2, 64));
        holds[4] = HOLD_RESET;
        holds[5] = 32'hFFFF_FFFF;
        holds[6] = t_tick'($urandom_range(100, 5000));
        holds[7] = t_tick'($urandom());
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_directed();
        for (int p = 0; p < 8; p++) begin
            quiet = (p % 3 == 2);
            run_random_phase(holds[p], PHASE_ITEMS);
        end
        quiet = 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);
        if (sb.fails == 0) begin
            $display("multi_input_debounce_scanner_unit regression: pass");
        end else begin
            $display("multi_input_debounce_scanner_unit regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/mids_pkg.sv
rtl/core/mids_cell.sv
rtl/core/multi_input_debounce_scanner_unit.sv
dv/multi_input_debounce_scanner_unit_test.sv
